@@ hw/rtl/assert_macros.svh @@
// assertion macros for the rtl files, included by the tach period filter top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// condition that must never hold
`define ASSERT_NEVER(lbl, cond) `ASSERT_CLK(lbl, !(cond))
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif

`endif

@@ hw/rtl/tpf_pkg.sv @@
// types, constants and codes for the tach period filter
package tpf_pkg;

    // input word: tach edge check-in or poll
    typedef struct packed {
        logic        func;
        logic [31:0] time_us;
    } tpf_in_t;

    // output word
    typedef struct packed {
        logic        signal_valid;
        logic [31:0] freq_hz;
        logic [37:0] speed_rpm;
    } tpf_out_t;

    localparam logic FUNC_EDGE = 1'b0;
    localparam logic FUNC_POLL = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELTA   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd2;

    localparam logic [15:0] FILTER_GAIN_RST = 16'd6554;
    localparam logic [31:0] MIN_DELTA_RST   = 32'd1000;
    localparam logic [31:0] TIMEOUT_RST     = 32'd1000000;

    // period is Q32.8, so numerators carry 2^8 * 2^12
    localparam int DIV_W = 46;
    localparam logic [DIV_W-1:0] FREQ_NUM = 46'd1000000 << 20;
    localparam logic [DIV_W-1:0] RPM_NUM  = 46'd60000000 << 20;
    localparam logic [31:0] FREQ_MAX = 32'hFFFF_FFFF;
    localparam logic [37:0] RPM_MAX  = {38{1'b1}};

    localparam int MUL_STEPS = 16;
    localparam int CNT_W = 6;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_EVAL  = 6'b000010,
        ST_MLOAD = 6'b000100,
        ST_MUL   = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_PUT   = 6'b100000
    } tpf_state_t;

    typedef struct packed {
        logic item_load;
        logic edge_update;
        logic flags_clear;
        logic reload;
        logic mul_load;
        logic mul_step;
        logic filt_write;
        logic div_load;
        logic div_step;
        logic res_invalid;
        logic out_load;
    } tpf_cmd_t;

    typedef struct packed {
        logic is_poll;
        logic edge_seen;
        logic prior_seen;
        logic lt_min;
        logic timed_out;
        logic mul_last;
        logic div_last;
    } tpf_stat_t;

endpackage

@@ hw/rtl/tach_period_filter_freq.sv @@
// Tach period filter: each input word is a tach edge (func 0) or a poll (func 1) with a
// 32-bit microsecond timestamp. An edge is finished in the evaluation state, or, when its
// period is lowpass filtered, after a serial shift-add multiplier, one gain bit per cycle.
// A poll that yields valid data runs the 46-step restoring divider that forms frequency and
// rpm side by side; a poll that reports no signal skips it. A further word is taken only
// after the current one is finished, while a finished result may still wait in the output
// register. Config writes are always ready.
module tach_period_filter_freq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  tpf_pkg::tpf_in_t                  in_word,
    output logic                              out_valid,
    input  logic                              out_stall,
    output tpf_pkg::tpf_out_t                 out_word,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tpf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                       cfg_data
);
    import tpf_pkg::*;

    tpf_cmd_t   cmd;
    tpf_stat_t  stat;
    tpf_state_t state;

    assign cfg_ready = 1'b1;

    tpf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd),
        .state     (state)
    );

    tpf_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_word  (out_word)
    );

`include "assert_macros.svh"

    // prior-edge flag is never set without the edge-seen flag
    `ASSERT_NEVER(a_flag_order, stat.prior_seen && !stat.edge_seen)
    // a new output word only comes from the handoff state
    `ASSERT_CLK(a_out_from_put, $rose(out_valid) |-> $past(state == ST_PUT))
    // a word reporting no signal carries zero values
    `ASSERT_CLK(a_invalid_zero, (out_valid && !out_word.signal_valid) |->
        (out_word.freq_hz == '0 && out_word.speed_rpm == '0))

endmodule

@@ hw/rtl/tpf_dp.sv @@
// datapath: config, edge state, serial filter multiplier, dual divider, output word
module tpf_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tpf_pkg::tpf_in_t                   in_word,
    input  logic                               cfg_we,
    input  logic [tpf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                        cfg_data,
    input  tpf_pkg::tpf_cmd_t                  cmd,
    output tpf_pkg::tpf_stat_t                 stat,
    output tpf_pkg::tpf_out_t                  out_word
);
    import tpf_pkg::*;

    logic [15:0]      filter_gain_reg;
    logic [31:0]      min_delta_reg;
    logic [31:0]      timeout_reg;

    tpf_in_t          item_reg;
    logic [31:0]      last_edge_reg;
    logic             edge_seen_reg;
    logic             prior_seen_reg;
    logic [39:0]      period_reg;
    logic [31:0]      delta_reg;

    logic [57:0]      acc_reg;
    logic [57:0]      acc_next;
    logic [56:0]      dsh_reg;
    logic [15:0]      ash_reg;
    logic [40:0]      diff;

    logic [CNT_W-1:0] cnt_reg;

    logic [39:0]      rem_f_reg;
    logic [39:0]      rem_r_reg;
    logic [DIV_W-1:0] num_f_reg;
    logic [DIV_W-1:0] num_r_reg;
    logic [DIV_W-1:0] q_f_reg;
    logic [DIV_W-1:0] q_r_reg;
    logic [40:0]      trial_f;
    logic [40:0]      trial_r;
    logic [40:0]      sub_f;
    logic [40:0]      sub_r;
    logic             ge_f;
    logic             ge_r;
    logic             res_valid_reg;

    tpf_out_t         out_reg;
    tpf_out_t         out_next;

    logic [31:0]      delta;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_gain_reg <= FILTER_GAIN_RST;
            min_delta_reg   <= MIN_DELTA_RST;
            timeout_reg     <= TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FILTER_GAIN: filter_gain_reg <= cfg_data[15:0];
                CFG_MIN_DELTA:   min_delta_reg   <= cfg_data;
                CFG_TIMEOUT:     timeout_reg     <= cfg_data;
                default:         ;
            endcase
        end
    end

    // wrapped time since the last edge, used both for edges and polls
    assign delta = item_reg.time_us - last_edge_reg;

    assign stat.is_poll    = (item_reg.func == FUNC_POLL);
    assign stat.edge_seen  = edge_seen_reg;
    assign stat.prior_seen = prior_seen_reg;
    assign stat.lt_min     = (delta < min_delta_reg);
    assign stat.timed_out  = (delta >= timeout_reg);
    assign stat.mul_last   = (cnt_reg == CNT_W'(MUL_STEPS - 1));
    assign stat.div_last   = (cnt_reg == CNT_W'(DIV_W - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            item_reg <= in_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_edge_reg  <= '0;
            edge_seen_reg  <= 1'b0;
            prior_seen_reg <= 1'b0;
            period_reg     <= '0;
        end
        else
        begin
            if (cmd.edge_update)
            begin
                last_edge_reg  <= item_reg.time_us;
                prior_seen_reg <= edge_seen_reg;
                edge_seen_reg  <= 1'b1;
            end
            else if (cmd.flags_clear)
            begin
                edge_seen_reg  <= 1'b0;
                prior_seen_reg <= 1'b0;
            end
            if (cmd.reload)
            begin
                period_reg <= {delta, 8'h00};
            end
            else if (cmd.filt_write)
            begin
                period_reg <= acc_next[55:16];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.edge_update)
        begin
            delta_reg <= delta;
        end
    end

    // y' = y + (x - y) * a, accumulated one gain bit per cycle, with rounding
    assign diff     = {1'b0, delta_reg, 8'h00} - {1'b0, period_reg};
    assign acc_next = acc_reg + (ash_reg[0] ? {dsh_reg[56], dsh_reg} : 58'd0);

    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            acc_reg <= {2'b00, period_reg, 16'h0000} + 58'd32768;
            dsh_reg <= {{16{diff[40]}}, diff};
            ash_reg <= filter_gain_reg;
        end
        else if (cmd.mul_step)
        begin
            acc_reg <= acc_next;
            dsh_reg <= {dsh_reg[55:0], 1'b0};
            ash_reg <= {1'b0, ash_reg[15:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.mul_load || cmd.div_load)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.mul_step || cmd.div_step)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    // restoring division of both numerators by the period, one bit a cycle;
    // a zero period yields all ones, which then saturates
    assign trial_f = {rem_f_reg, num_f_reg[DIV_W-1]};
    assign trial_r = {rem_r_reg, num_r_reg[DIV_W-1]};
    assign sub_f   = trial_f - {1'b0, period_reg};
    assign sub_r   = trial_r - {1'b0, period_reg};
    assign ge_f    = (trial_f >= {1'b0, period_reg});
    assign ge_r    = (trial_r >= {1'b0, period_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            rem_f_reg <= '0;
            rem_r_reg <= '0;
            num_f_reg <= FREQ_NUM;
            num_r_reg <= RPM_NUM;
        end
        else if (cmd.div_step)
        begin
            rem_f_reg <= ge_f ? sub_f[39:0] : trial_f[39:0];
            rem_r_reg <= ge_r ? sub_r[39:0] : trial_r[39:0];
            num_f_reg <= {num_f_reg[DIV_W-2:0], 1'b0};
            num_r_reg <= {num_r_reg[DIV_W-2:0], 1'b0};
            q_f_reg   <= {q_f_reg[DIV_W-2:0], ge_f};
            q_r_reg   <= {q_r_reg[DIV_W-2:0], ge_r};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.div_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (cmd.res_invalid)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        out_next.signal_valid = res_valid_reg;
        out_next.freq_hz      = '0;
        out_next.speed_rpm    = '0;
        if (res_valid_reg)
        begin
            out_next.freq_hz   = (|q_f_reg[DIV_W-1:32]) ? FREQ_MAX : q_f_reg[31:0];
            out_next.speed_rpm = (|q_r_reg[DIV_W-1:38]) ? RPM_MAX : q_r_reg[37:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign out_word = out_reg;

endmodule

@@ hw/rtl/tpf_ctrl.sv @@
// controller: sequences edge updates, filter steps, divisions and output handoff
module tpf_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    input  tpf_pkg::tpf_stat_t     stat,
    output tpf_pkg::tpf_cmd_t      cmd,
    output tpf_pkg::tpf_state_t    state
);
    import tpf_pkg::*;

    tpf_state_t state_reg;
    tpf_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    // output register can take a new word when empty or being drained
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.item_load = 1'b1;
                    state_next    = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (!stat.is_poll)
                begin
                    cmd.edge_update = 1'b1;
                    state_next      = ST_IDLE;
                    if (stat.edge_seen)
                    begin
                        if (stat.lt_min)
                        begin
                            state_next = ST_MLOAD;
                        end
                        else
                        begin
                            cmd.reload = 1'b1;
                        end
                    end
                end
                else if (stat.timed_out)
                begin
                    cmd.flags_clear = 1'b1;
                    cmd.res_invalid = 1'b1;
                    state_next      = ST_PUT;
                end
                else if (stat.edge_seen && stat.prior_seen)
                begin
                    cmd.div_load = 1'b1;
                    state_next   = ST_DIV;
                end
                else
                begin
                    cmd.res_invalid = 1'b1;
                    state_next      = ST_PUT;
                end
            end
            ST_MLOAD:
            begin
                cmd.mul_load = 1'b1;
                state_next   = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (stat.mul_last)
                begin
                    cmd.filt_write = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign state     = state_reg;

endmodule
